>>> hw/rtl/mlpq_pkg.sv
// ----------------------------------------------------------------------------
// mlpq_pkg
// shared constants, status codes and beat types for the multi-level queue
// ----------------------------------------------------------------------------
package mlpq_pkg;

    localparam int MAX_PRIORITY = 8;
    localparam int LEVEL_DEPTH  = 512;
    localparam int NUM_LEVELS   = MAX_PRIORITY + 1;

    localparam int LVL_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int PTR_W  = $clog2(LEVEL_DEPTH);
    localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
    localparam int ADDR_W = $clog2(NUM_LEVELS * LEVEL_DEPTH);
    localparam int MEM_DEPTH = NUM_LEVELS * LEVEL_DEPTH;
    localparam int DATA_W = 32;

    localparam logic FUNC_ADD    = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    localparam logic [2:0] STAT_ADDED     = 3'd0;
    localparam logic [2:0] STAT_REMOVED   = 3'd1;
    localparam logic [2:0] STAT_PRIO_HIGH = 3'd2;
    localparam logic [2:0] STAT_FULL      = 3'd3;
    localparam logic [2:0] STAT_EMPTY     = 3'd4;

    typedef struct packed {
        logic               func;
        logic signed [31:0] item_value;
        logic        [3:0]  priority_req;
    } in_item_t;

    typedef struct packed {
        logic        [2:0]  status;
        logic signed [31:0] out_value;
    } out_item_t;

endpackage

>>> hw/rtl/mlpq_ram.sv
// ----------------------------------------------------------------------------
// mlpq_ram
// single-port synchronous ram with registered read data
// ----------------------------------------------------------------------------
module mlpq_ram #(
    parameter int DEPTH  = 4608,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/mlpq_seq.sv
// ----------------------------------------------------------------------------
// mlpq_seq
// sequencer: level lookup, pointer/count update and store access per item
// ----------------------------------------------------------------------------
module mlpq_seq
    import mlpq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_busy,
    input  in_item_t          in_data,
    output logic              res_valid,
    input  logic              res_free,
    output out_item_t         res_data,
    output logic              mem_we,
    output logic              mem_re,
    output logic [ADDR_W-1:0] mem_addr,
    output logic [DATA_W-1:0] mem_wdata,
    input  logic [DATA_W-1:0] mem_rdata
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOOK = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]        state_reg, state_next;
    in_item_t          item_reg, item_next;
    logic [LVL_W-1:0]  lvl_reg, lvl_next;
    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [2:0]        stat_reg, stat_next;
    logic [DATA_W-1:0] val_reg, val_next;

    logic [PTR_W-1:0] head_reg [NUM_LEVELS];
    logic [PTR_W-1:0] tail_reg [NUM_LEVELS];
    logic [CNT_W-1:0] count_reg [NUM_LEVELS];

    logic             found;
    logic [LVL_W-1:0] enc_lvl;
    logic [LVL_W-1:0] look_lvl;
    logic [CNT_W-1:0] look_count;
    logic [PTR_W-1:0] look_ptr;
    logic             prio_ok;
    logic [PTR_W-1:0] ptr_wrap;

    // lowest non-empty level
    always_comb
    begin
        found   = 1'b0;
        enc_lvl = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--)
        begin
            if (count_reg[i] != '0)
            begin
                found   = 1'b1;
                enc_lvl = LVL_W'(i);
            end
        end
    end

    assign prio_ok  = ({1'b0, item_reg.priority_req} <= 5'(MAX_PRIORITY));
    assign look_lvl = (item_reg.func == FUNC_REMOVE) ? enc_lvl
                                                     : LVL_W'(item_reg.priority_req);

    always_comb
    begin
        look_count = '0;
        look_ptr   = '0;
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            if (look_lvl == LVL_W'(i))
            begin
                look_count = count_reg[i];
                look_ptr   = (item_reg.func == FUNC_REMOVE) ? head_reg[i] : tail_reg[i];
            end
        end
    end

    // shared wrap incrementer for head or tail
    assign ptr_wrap = (ptr_reg == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        lvl_next   = lvl_reg;
        ptr_next   = ptr_reg;
        addr_next  = addr_reg;
        stat_next  = stat_reg;
        val_next   = val_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                lvl_next  = look_lvl;
                ptr_next  = look_ptr;
                addr_next = ADDR_W'(ADDR_W'(look_lvl) * ADDR_W'(LEVEL_DEPTH))
                          + ADDR_W'(look_ptr);
                val_next  = '0;
                state_next = S_DONE;
                if (item_reg.func == FUNC_REMOVE)
                begin
                    if (found)
                    begin
                        state_next = S_EXEC;
                    end
                    else
                    begin
                        stat_next = STAT_EMPTY;
                    end
                end
                else if (!prio_ok)
                begin
                    stat_next = STAT_PRIO_HIGH;
                end
                else if (look_count == CNT_W'(LEVEL_DEPTH))
                begin
                    stat_next = STAT_FULL;
                end
                else
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (item_reg.func == FUNC_REMOVE)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    stat_next  = STAT_ADDED;
                    state_next = S_DONE;
                end
            end
            S_READ:
            begin
                stat_next  = STAT_REMOVED;
                val_next   = mem_rdata;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_EXEC)
            begin
                for (int i = 0; i < NUM_LEVELS; i++)
                begin
                    if (lvl_reg == LVL_W'(i))
                    begin
                        if (item_reg.func == FUNC_REMOVE)
                        begin
                            head_reg[i]  <= ptr_wrap;
                            count_reg[i] <= count_reg[i] - 1'b1;
                        end
                        else
                        begin
                            tail_reg[i]  <= ptr_wrap;
                            count_reg[i] <= count_reg[i] + 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        lvl_reg  <= lvl_next;
        ptr_reg  <= ptr_next;
        addr_reg <= addr_next;
        stat_reg <= stat_next;
        val_reg  <= val_next;
    end

    assign in_busy   = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res_data  = '{status: stat_reg, out_value: val_reg};
    assign mem_we    = (state_reg == S_EXEC) && (item_reg.func == FUNC_ADD);
    assign mem_re    = (state_reg == S_EXEC) && (item_reg.func == FUNC_REMOVE);
    assign mem_addr  = addr_reg;
    assign mem_wdata = item_reg.item_value;

endmodule

>>> hw/rtl/multi_level_priority_queue.sv
// ----------------------------------------------------------------------------
// multi_level_priority_queue
// priority queue of one circular fifo per level, level 0 served first
// ----------------------------------------------------------------------------
// One item at a time: an accepted beat is looked up, applied and answered by
// a small sequencer around a single-port store of NUM_LEVELS*LEVEL_DEPTH words
// and one shared pointer incrementer. An add passes the lookup, execute and
// done states, a remove adds a read state (the store read is registered), a
// rejected add or a remove on an empty queue goes from lookup to done; the
// sequencer returns to idle for the next beat as the result is loaded into
// the output register, which holds a result until it is taken, and the input
// may be accepted meanwhile. No clearing pass after reset: pointers and counts
// clear at once, and the store is only read at entries written earlier.
module multi_level_priority_queue
    import mlpq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    logic              busy;
    logic              res_valid;
    logic              res_free;
    out_item_t         res_data;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_addr;
    logic [DATA_W-1:0] mem_wdata;
    logic [DATA_W-1:0] mem_rdata;

    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg;

    mlpq_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_busy   (busy),
        .in_data   (in_data),
        .res_valid (res_valid),
        .res_free  (res_free),
        .res_data  (res_data),
        .mem_we    (mem_we),
        .mem_re    (mem_re),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    mlpq_ram #(
        .DEPTH  (MEM_DEPTH),
        .WIDTH  (DATA_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // output slot is free when empty or its beat leaves this cycle
    assign res_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (res_valid && res_free)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_free)
        begin
            out_data_reg <= res_data;
        end
    end

    assign in_stall  = busy;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
